// File: sv/assert_macros.svh
// Assertion macros for the insertion sort RTL.
// No dependencies; included inside module bodies that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, masked while reset is applied
`define ISRT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("insertion sort check failed");

// Implication held in the cycle after the trigger
`define ISRT_ASSERT_NEXT(lbl, trig, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
	else $error("insertion sort sequencing check failed");

`endif

// File: sv/isrt_pkg.sv
// Types shared by the insertion sort cells and the top level.
// No dependencies.
`default_nettype none

package isrt_pkg;

	// Element width, fixed by the data format
	localparam int unsigned ValW = 32;

	// Data handed from one cell to the next one up
	typedef struct packed {
		logic signed [ValW-1:0] value;
		logic                   gt;    // stored value is greater than the new one
		logic                   occ;   // cell holds an element
	} isrt_link_t;

	// Per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;    // insert the new value
		logic shift;  // move every element one place down
	} isrt_ctrl_t;

endpackage

`default_nettype wire

// File: sv/isrt_cell.sv
// One compare-and-shift cell of the insertion sort chain.
// Depends on isrt_pkg.
`default_nettype none

module isrt_cell (
	input  wire logic                              clk,
	input  wire isrt_pkg::isrt_ctrl_t              ctrl,
	input  wire logic signed [isrt_pkg::ValW-1:0]  new_value,
	input  wire logic                              occ,
	input  wire isrt_pkg::isrt_link_t              lo_link,
	input  wire logic signed [isrt_pkg::ValW-1:0]  hi_value,
	output isrt_pkg::isrt_link_t                   link
);
	import isrt_pkg::*;

	logic signed [ValW-1:0] value_q;
	logic                   gt;

	// Strictly greater keeps equal values in arrival order
	assign gt   = occ && (value_q > new_value);
	assign link = '{value: value_q, gt: gt, occ: occ};

	// Insert: take the lower neighbour if it moves up, else the new value
	// when this is its slot. Drain: take the upper neighbour.
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			value_q <= hi_value;
		end else if (ctrl.ins) begin
			if (lo_link.gt) begin
				value_q <= lo_link.value;
			end else if (gt || (!occ && lo_link.occ)) begin
				value_q <= new_value;
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/insertion_sort_engine.sv
// Insertion sort engine: one request per cycle while loading; each request is inserted
// by a chain of DEPTH compare-and-shift cells in the cycle it is taken.
// After the request marked last, busy rises and the chain drains one element per cycle:
// N results for N stored elements, the first once the drain state has loaded the output registers.
// The receiver cannot stall; results come on consecutive cycles.
// Asynchronous active-low reset clears the count, overflow flag, sequencer and result outputs.
`default_nettype none

module insertion_sort_engine #(
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic signed [isrt_pkg::ValW-1:0]  value,
	input  wire logic                              last,
	output logic                                   strobe,
	output logic signed [isrt_pkg::ValW-1:0]       sorted_value,
	output logic                                   last_out,
	output logic                                   dropped
);
	import isrt_pkg::*;
	`include "assert_macros.svh"

	localparam int unsigned CntW = $clog2(DEPTH + 1);

	typedef enum logic {ST_LOAD, ST_DRAIN} state_t;

	state_t                 state_q;
	logic [CntW-1:0]        count_q;
	logic                   ovf_q;
	logic                   strobe_q;
	logic signed [ValW-1:0] sorted_value_q;
	logic                   last_out_q;
	logic                   dropped_q;

	logic                   accept;
	logic                   full;
	isrt_ctrl_t             ctrl;
	isrt_link_t             link [DEPTH];

	assign busy   = (state_q == ST_DRAIN);
	assign accept = start && !busy;
	assign full   = (count_q == CntW'(DEPTH));
	assign ctrl   = '{ins: accept && !full, shift: busy};

	// Cell chain; cell 0 holds the smallest element
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		isrt_link_t             lo_link;
		logic signed [ValW-1:0] hi_value;
		logic                   occ;

		assign occ = (count_q > CntW'(i));

		if (i == 0) begin : g_first
			assign lo_link = '{value: '0, gt: 1'b0, occ: 1'b1};
		end else begin : g_mid
			assign lo_link = link[i-1];
		end

		if (i == DEPTH - 1) begin : g_top
			assign hi_value = link[i].value;
		end else begin : g_below
			assign hi_value = link[i+1].value;
		end

		isrt_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.new_value (value),
			.occ       (occ),
			.lo_link   (lo_link),
			.hi_value  (hi_value),
			.link      (link[i])
		);
	end

	// Sequencer: count requests, then drain the chain through cell 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_LOAD;
			count_q        <= '0;
			ovf_q          <= 1'b0;
			strobe_q       <= 1'b0;
			sorted_value_q <= '0;
			last_out_q     <= 1'b0;
			dropped_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					strobe_q   <= 1'b0;
					last_out_q <= 1'b0;
					if (accept) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + CntW'(1);
						end
						if (last) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					strobe_q       <= 1'b1;
					sorted_value_q <= link[0].value;
					last_out_q     <= (count_q == CntW'(1));
					dropped_q      <= ovf_q;
					count_q        <= count_q - CntW'(1);
					if (count_q == CntW'(1)) begin
						state_q <= ST_LOAD;
						ovf_q   <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign strobe       = strobe_q;
	assign sorted_value = sorted_value_q;
	assign last_out     = last_out_q;
	assign dropped      = dropped_q;

	// Checks
	`ISRT_ASSERT(a_drain_nonempty, busy |-> (count_q != '0))
	`ISRT_ASSERT(a_strobe_from_drain, strobe |-> $past(busy))
	`ISRT_ASSERT_NEXT(a_final_ends_drain, busy && (count_q == CntW'(1)), last_out && !busy)
	`ISRT_ASSERT(a_count_bound, count_q <= CntW'(DEPTH))

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for insertion_sort_engine: directed and random request sets,
// every sorted result compared against the row's expected result or an in-bench insertion sort model.
// Depends on isrt_pkg and the insertion_sort_engine RTL.

module tb;

	import isrt_pkg::*;

	localparam int unsigned StoreDepth = 64;
	localparam int QuietLimit = 2000;
	localparam int DirectedRows = 17;
	localparam int RandomRequests = 37;

	typedef logic signed [ValW-1:0] elem_t;

	typedef struct packed {
		elem_t value;
		logic  last;
	} request_t;

	typedef struct packed {
		elem_t value;
		logic  last;
		logic  dropped;
	} sorted_t;

	typedef struct packed {
		request_t req;
		logic     typed;   // expected result written in the row
		sorted_t  res;
	} directed_row_t;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	elem_t value;
	logic  last;
	logic  strobe;
	elem_t sorted_value;
	logic  last_out;
	logic  dropped;

	// Bench copy of the store and the expected results in order of arrival
	elem_t   sorted_model[$];
	logic    overflow_model;
	sorted_t pending_results[$];

	int  mismatch_count;
	int  quiet_cycles;
	bit  no_idle;

	directed_row_t directed_rows [DirectedRows];

	insertion_sort_engine #(
		.DEPTH(StoreDepth)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.value(value),
		.last(last),
		.strobe(strobe),
		.sorted_value(sorted_value),
		.last_out(last_out),
		.dropped(dropped)
	);

	// Clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Insert one accepted request into the model; a last request flushes the set
	task automatic sort_model_take(input request_t req, input logic use_model);
		int pos;
		sorted_t res;
		begin
			if (sorted_model.size() < StoreDepth) begin
				pos = sorted_model.size();
				// strictly greater entries move up, so equal values keep arrival order
				while (pos > 0 && sorted_model[pos-1] > req.value)
					pos--;
				sorted_model.insert(pos, req.value);
			end else begin
				overflow_model = 1'b1;
			end
			if (req.last) begin
				if (use_model) begin
					for (int k = 0; k < sorted_model.size(); k++) begin
						res.value = sorted_model[k];
						res.last = (k == sorted_model.size() - 1);
						res.dropped = overflow_model;
						pending_results.push_back(res);
					end
				end
				sorted_model.delete();
				overflow_model = 1'b0;
			end
		end
	endtask

	// Present one request and hold it until the block takes it
	task automatic send_request(input request_t req, input logic typed, input sorted_t res);
		begin
			@(negedge clk);
			while (!no_idle && $urandom_range(0, 99) < 19) begin
				start <= 1'b0;
				value <= $urandom;
				last <= 1'($urandom_range(0, 1));
				@(negedge clk);
			end
			start <= 1'b1;
			value <= req.value;
			last <= req.last;
			do @(posedge clk); while (busy);
			if (typed)
				pending_results.push_back(res);
			sort_model_take(req, !typed);
		end
	endtask

	// Extremes, tiny values and a spread of full-width words
	function automatic elem_t random_element();
		case ($urandom_range(0, 9))
			0: random_element = 32'sh7fffffff;
			1: random_element = 32'sh80000000;
			2, 3: random_element = $urandom_range(0, 15) - 8;
			default: random_element = $urandom;
		endcase
	endfunction

	// One set of random values, the final one marked last
	task automatic send_random_set(input int size);
		request_t req;
		sorted_t none;
		begin
			none = '0;
			for (int i = 0; i < size; i++) begin
				req.value = random_element();
				req.last = (i == size - 1);
				send_request(req, 1'b0, none);
			end
		end
	endtask

	// Result checker: the receiver cannot stall, so every strobe is taken
	always @(posedge clk) begin
		sorted_t exp;
		if (arst_n && strobe) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result value %0d last %0b dropped %0b",
					$time, sorted_value, last_out, dropped);
				mismatch_count++;
			end else begin
				exp = pending_results.pop_front();
				if (sorted_value !== exp.value) begin
					$display("%0t: sorted_value expected %0d got %0d",
						$time, exp.value, sorted_value);
					mismatch_count++;
				end
				if (last_out !== exp.last) begin
					$display("%0t: last_out expected %0b got %0b", $time, exp.last, last_out);
					mismatch_count++;
				end
				if (dropped !== exp.dropped) begin
					$display("%0t: dropped expected %0b got %0b", $time, exp.dropped, dropped);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog on cycles with neither a request nor a result taken
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QuietLimit) begin
				$display("%0t: no progress, %0d results outstanding", $time,
					pending_results.size());
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		int sent;
		start = 1'b0;
		value = '0;
		last = 1'b0;
		arst_n = 1'b0;
		overflow_model = 1'b0;
		mismatch_count = 0;
		quiet_cycles = 0;
		no_idle = 1'b0;

		// value, last, typed, expected value / last_out / dropped
		directed_rows[0]  = '{'{32'sh7fffffff, 1'b1}, 1'b1, '{32'sh7fffffff, 1'b1, 1'b0}};
		directed_rows[1]  = '{'{32'sh80000000, 1'b1}, 1'b1, '{32'sh80000000, 1'b1, 1'b0}};
		directed_rows[2]  = '{'{32'sh00000000, 1'b1}, 1'b1, '{32'sh00000000, 1'b1, 1'b0}};
		directed_rows[3]  = '{'{32'shffffffff, 1'b1}, 1'b1, '{32'shffffffff, 1'b1, 1'b0}};
		// mixed set with a repeated value and both extremes
		directed_rows[4]  = '{'{32'sd5, 1'b0}, 1'b0, '0};
		directed_rows[5]  = '{'{-32'sd3, 1'b0}, 1'b0, '0};
		directed_rows[6]  = '{'{32'sd5, 1'b0}, 1'b0, '0};
		directed_rows[7]  = '{'{32'sh7fffffff, 1'b0}, 1'b0, '0};
		directed_rows[8]  = '{'{32'sh80000000, 1'b0}, 1'b0, '0};
		directed_rows[9]  = '{'{-32'sd1, 1'b0}, 1'b0, '0};
		directed_rows[10] = '{'{32'sd0, 1'b0}, 1'b0, '0};
		directed_rows[11] = '{'{32'sd1, 1'b1}, 1'b0, '0};
		// descending pair
		directed_rows[12] = '{'{32'sd100, 1'b0}, 1'b0, '0};
		directed_rows[13] = '{'{-32'sd100, 1'b1}, 1'b0, '0};
		// alternating bit patterns
		directed_rows[14] = '{'{32'sh55555555, 1'b0}, 1'b0, '0};
		directed_rows[15] = '{'{32'shaaaaaaaa, 1'b0}, 1'b0, '0};
		directed_rows[16] = '{'{32'sh55555555, 1'b1}, 1'b0, '0};

		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// Directed table
		for (int r = 0; r < DirectedRows; r++)
			send_request(directed_rows[r].req, directed_rows[r].typed, directed_rows[r].res);

		// Store fills, then drops a plain request and the last one, with no idling
		no_idle = 1'b1;
		send_random_set(StoreDepth + 2);
		no_idle = 1'b0;

		// Small random sets, an occasional longer one
		sent = 0;
		while (sent < RandomRequests) begin
			int size;
			size = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
			no_idle = ($urandom_range(0, 5) == 0);
			send_random_set(size);
			sent += size;
		end
		no_idle = 1'b0;

		@(negedge clk);
		start <= 1'b0;

		// Drain, then a few cycles to catch stray results
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: files.f
+incdir+sv
sv/isrt_pkg.sv
sv/isrt_cell.sv
sv/insertion_sort_engine.sv
bench/tb.sv
